>>> rtl/ffal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffal_pkg
// Shared types and constants of the free frame list allocator.
// ----------------------------------------------------------------------------
package ffal_pkg;

   localparam int FFAL_MAX_FRAMES = 4096;
   localparam int FFAL_COUNT_W    = 13;
   localparam int FFAL_FRAME_W    = 12;
   localparam int FFAL_PAGES_W    = 8;
   localparam int FFAL_REQ_W      = 2;
   localparam int FFAL_STATUS_W   = 3;
   localparam int FFAL_REQ_DATA_W = 24;
   localparam int FFAL_RSP_DATA_W = 16;
   localparam int FFAL_CSR_IDX_W  = 1;

   localparam logic [FFAL_COUNT_W-1:0] FFAL_COUNT_RST = 13'd4096;
   localparam logic [FFAL_FRAME_W-1:0] FFAL_FIRST_RST = 12'd0;

   typedef enum logic [FFAL_CSR_IDX_W-1:0] {
      CSR_FRAME_COUNT = 1'd0,
      CSR_FIRST_FREE  = 1'd1
   } ffal_csr_type;

   typedef enum logic [FFAL_REQ_W-1:0] {
      REQ_INIT  = 2'd0,
      REQ_ALLOC = 2'd1,
      REQ_FREE  = 2'd2
   } ffal_req_type;

   typedef enum logic [FFAL_STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_SIZE      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_INIT  = 3'd3,
      ST_BAD_FRAME = 3'd4
   } ffal_status_type;

   typedef enum logic [1:0] {
      FS_IDLE  = 2'd0,
      FS_SWEEP = 2'd1,
      FS_READ  = 2'd2
   } ffal_state_type;

   typedef struct packed {
      logic            init_start;
      logic            sweep_step;
      logic            alloc_read;
      logic            alloc_pop;
      logic            free_push;
      logic            push;
      ffal_status_type push_status;
   } ffal_cmd_type;

   typedef struct packed {
      ffal_req_type kind;
      logic         ready;
      logic         page_one;
      logic         frame_bad;
      logic         head_nil;
      logic         init_empty;
      logic         sweep_last;
      logic         out_room;
   } ffal_stat_type;

endpackage
`default_nettype wire

>>> rtl/ffal_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffal_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ffal_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/ffal_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffal_ctrl
// Request sequencer: decodes accepted words, runs the init sweep and the
// alloc link read, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ffal_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire ffal_pkg::ffal_stat_type stat,
   output ffal_pkg::ffal_cmd_type       cmd
);
   import ffal_pkg::*;

   ffal_state_type state_ff;
   ffal_state_type state_in;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == FS_IDLE) && stat.out_room;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.push_status = ST_OK;
      unique case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               unique case (stat.kind)
                  REQ_INIT: begin
                     cmd.init_start = 1'b1;
                     if (stat.init_empty) begin
                        cmd.push = 1'b1;
                     end else begin
                        state_in = FS_SWEEP;
                     end
                  end
                  REQ_ALLOC: begin
                     if (!stat.ready) begin
                        cmd.push        = 1'b1;
                        cmd.push_status = ST_NOT_INIT;
                     end else if (!stat.page_one) begin
                        cmd.push        = 1'b1;
                        cmd.push_status = ST_SIZE;
                     end else if (stat.head_nil) begin
                        cmd.push        = 1'b1;
                        cmd.push_status = ST_EMPTY;
                     end else begin
                        cmd.alloc_read = 1'b1;
                        state_in       = FS_READ;
                     end
                  end
                  REQ_FREE: begin
                     cmd.push = 1'b1;
                     if (!stat.ready) begin
                        cmd.push_status = ST_NOT_INIT;
                     end else if (stat.frame_bad) begin
                        cmd.push_status = ST_BAD_FRAME;
                     end else begin
                        cmd.free_push = 1'b1;
                     end
                  end
                  default: begin
                     cmd.push = 1'b1;
                  end
               endcase
            end
         end
         FS_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               cmd.push = 1'b1;
               state_in = FS_IDLE;
            end
         end
         FS_READ: begin
            cmd.alloc_pop = 1'b1;
            cmd.push      = 1'b1;
            state_in      = FS_IDLE;
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_read |=> cmd.alloc_pop)
      else $error("alloc read not followed by pop");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> stat.out_room)
      else $error("result pushed with output queue full");

   a_sweep_only_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FS_SWEEP) |-> stat.ready)
      else $error("sweep running before init latched");

endmodule
`default_nettype wire

>>> rtl/ffal_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffal_dpath
// Allocator datapath: config registers, list head, link memory, sweep
// counter and the two-entry result queue.
// ----------------------------------------------------------------------------
module ffal_dpath #(
   parameter int MAX_FRAMES = ffal_pkg::FFAL_MAX_FRAMES
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [ffal_pkg::FFAL_CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ffal_pkg::FFAL_COUNT_W-1:0]    csr_wdata,
   input  wire logic [ffal_pkg::FFAL_REQ_DATA_W-1:0] req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [ffal_pkg::FFAL_RSP_DATA_W-1:0] rsp_tdata,
   input  wire ffal_pkg::ffal_cmd_type               cmd,
   output ffal_pkg::ffal_stat_type                   stat
);
   import ffal_pkg::*;

   localparam int ADDR_W = $clog2(MAX_FRAMES);
   localparam int LINK_W = ADDR_W + 1;
   localparam int CW     = (FFAL_COUNT_W > LINK_W) ? FFAL_COUNT_W : LINK_W;
   localparam int FW     = (FFAL_FRAME_W > LINK_W) ? FFAL_FRAME_W : LINK_W;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_FRAMES);

   logic [FFAL_COUNT_W-1:0]    frame_count_ff;
   logic [FFAL_FRAME_W-1:0]    first_free_ff;
   logic [LINK_W-1:0]          active_ff;
   logic [LINK_W-1:0]          head_ff;
   logic                       ready_ff;
   logic [LINK_W-1:0]          sweep_ff;

   logic [CW-1:0]              count_ext;
   logic [CW-1:0]              max_ext;
   logic [LINK_W-1:0]          sat_n;
   logic [FFAL_FRAME_W-1:0]    req_frame;
   logic [FW-1:0]              frame_ext;
   logic [LINK_W-1:0]          sweep_nxt;
   logic [LINK_W-1:0]          sweep_data;
   logic                       init_empty;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [LINK_W-1:0]          wr_data;
   logic [LINK_W-1:0]          rd_data;

   logic [FFAL_RSP_DATA_W-1:0] push_word;
   logic [FFAL_FRAME_W-1:0]    push_index;
   logic                       pop;
   logic                       out_valid_ff;
   logic [FFAL_RSP_DATA_W-1:0] out_data_ff;
   logic                       skid_valid_ff;
   logic [FFAL_RSP_DATA_W-1:0] skid_data_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FFAL_COUNT_RST;
         first_free_ff  <= FFAL_FIRST_RST;
      end else if (csr_we) begin
         unique case (ffal_csr_type'(csr_index))
            CSR_FRAME_COUNT: frame_count_ff <= csr_wdata;
            CSR_FIRST_FREE:  first_free_ff  <= csr_wdata[FFAL_FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   assign count_ext  = CW'(frame_count_ff);
   assign max_ext    = CW'(MAX_FRAMES);
   assign sat_n      = (count_ext > max_ext) ? LINK_W'(max_ext) : LINK_W'(count_ext);
   assign init_empty = FW'(first_free_ff) >= FW'(sat_n);

   assign req_frame  = req_tdata[21:10];
   assign frame_ext  = FW'(req_frame);

   assign sweep_nxt  = sweep_ff + LINK_W'(1);
   assign sweep_data = (sweep_nxt >= active_ff) ? NIL : sweep_nxt;

   // list state
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= 1'b0;
         head_ff   <= NIL;
         active_ff <= '0;
         sweep_ff  <= '0;
      end else begin
         if (cmd.init_start) begin
            ready_ff  <= 1'b1;
            active_ff <= sat_n;
            head_ff   <= init_empty ? NIL : LINK_W'(first_free_ff);
            sweep_ff  <= LINK_W'(first_free_ff);
         end else if (cmd.sweep_step) begin
            sweep_ff <= sweep_nxt;
         end else if (cmd.free_push) begin
            head_ff <= LINK_W'(frame_ext);
         end else if (cmd.alloc_pop) begin
            head_ff <= rd_data;
         end
      end
   end

   assign wr_en   = cmd.sweep_step || cmd.free_push;
   assign wr_addr = cmd.sweep_step ? sweep_ff[ADDR_W-1:0] : frame_ext[ADDR_W-1:0];
   assign wr_data = cmd.sweep_step ? sweep_data : head_ff;

   ffal_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_FRAMES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.alloc_read),
      .rd_addr (head_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // result queue: output register plus skid entry
   assign push_index = cmd.alloc_pop ? FFAL_FRAME_W'(head_ff) : '0;
   assign push_word  = {1'b0, push_index, cmd.push_status};
   assign pop        = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= cmd.push;
            skid_data_ff  <= push_word;
         end else begin
            out_valid_ff <= cmd.push;
            out_data_ff  <= push_word;
         end
      end else if (cmd.push) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
            skid_data_ff  <= push_word;
         end else begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= push_word;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign stat.kind       = ffal_req_type'(req_tdata[1:0]);
   assign stat.ready      = ready_ff;
   assign stat.page_one   = req_tdata[9:2] == FFAL_PAGES_W'(1);
   assign stat.frame_bad  = frame_ext >= FW'(active_ff);
   assign stat.head_nil   = head_ff == NIL;
   assign stat.init_empty = init_empty;
   assign stat.sweep_last = sweep_nxt >= active_ff;
   assign stat.out_room   = !skid_valid_ff;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      (ready_ff && (head_ff != NIL)) |-> (head_ff < active_ff))
      else $error("list head beyond active frame count");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> (sweep_ff < active_ff))
      else $error("init sweep beyond active frame count");

endmodule
`default_nettype wire

>>> rtl/free_frame_list_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// free_frame_list_allocator_unit
// Single-page frame allocator on a linked free list held in a link RAM.
// ----------------------------------------------------------------------------
// One request word is in work at a time and gives one response word. Free
// and every error response are pushed straight from the idle state; a good
// alloc first reads the next link of the head frame from the registered
// read port of the link RAM. Init latches the frame count and then sweeps
// each frame from first_free up to the latched frame count, one link RAM
// write each; an init that yields an empty list skips the sweep. A request
// is taken while the previous response still waits on the rsp side. Config
// may be written only while the unit is idle. The link RAM needs no
// clearing: init writes every link that can later be read.
// ----------------------------------------------------------------------------
module free_frame_list_allocator_unit #(
   parameter int MAX_FRAMES = ffal_pkg::FFAL_MAX_FRAMES
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [ffal_pkg::FFAL_CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ffal_pkg::FFAL_COUNT_W-1:0]    csr_wdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [1:0] req_type, [9:2] page_count, [21:10] free_frame, [23:22] zero
   input  wire logic [ffal_pkg::FFAL_REQ_DATA_W-1:0] req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [2:0] status, [14:3] frame_index, [15] zero
   output logic      [ffal_pkg::FFAL_RSP_DATA_W-1:0] rsp_tdata
);
   import ffal_pkg::*;

   ffal_cmd_type  cmd;
   ffal_stat_type stat;

   ffal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffal_dpath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
`default_nettype wire

>>> sim/ffal_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffal_checker
// Watches the free frame list allocator's ports and checks every response.
// ----------------------------------------------------------------------------
// Follows table writes and accepted request words, and keeps its own copy of
// the link table, the list head and the init flag. For each request it
// queues the grant that it predicts. Each accepted response word is checked
// field by field against the oldest queued grant.
// ----------------------------------------------------------------------------
module ffal_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [ffal_pkg::FFAL_CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ffal_pkg::FFAL_COUNT_W-1:0]    csr_wdata,
   input  wire logic                                 req_tvalid,
   input  wire logic                                 req_tready,
   input  wire logic [ffal_pkg::FFAL_REQ_DATA_W-1:0] req_tdata,
   input  wire logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic [ffal_pkg::FFAL_RSP_DATA_W-1:0] rsp_tdata,
   output int                                        pending,
   output int                                        errors
);
   import ffal_pkg::*;

   localparam logic [FFAL_COUNT_W-1:0] NIL_FRAME = FFAL_COUNT_W'(FFAL_MAX_FRAMES);
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      ffal_status_type         status;
      logic [FFAL_FRAME_W-1:0] frame;
   } grant_type;

   logic [FFAL_COUNT_W-1:0] link_mem [FFAL_MAX_FRAMES];
   logic [FFAL_COUNT_W-1:0] head;
   logic                    list_ready;
   logic [FFAL_COUNT_W-1:0] live_count;
   logic [FFAL_COUNT_W-1:0] cfg_count;
   logic [FFAL_FRAME_W-1:0] cfg_first;
   grant_type               due_grants[$];

   task automatic flag_error(input string what, input int got, input int want);
      errors++;
      if (errors <= PRINT_CAP)
         $display("%0t ffal_checker: %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // counts above the table size saturate; the chain runs first..n-1
   task automatic build_free_list();
      int n;
      int i;
      n = (cfg_count > FFAL_MAX_FRAMES) ? FFAL_MAX_FRAMES : int'(cfg_count);
      live_count = FFAL_COUNT_W'(n);
      for (i = 0; i < FFAL_MAX_FRAMES; i++)
         link_mem[i] = NIL_FRAME;
      if (int'(cfg_first) < n) begin
         for (i = int'(cfg_first); i + 1 < n; i++)
            link_mem[i] = FFAL_COUNT_W'(i + 1);
         head = FFAL_COUNT_W'(cfg_first);
      end else begin
         head = NIL_FRAME;
      end
      list_ready = 1'b1;
   endtask

   task automatic apply_request(input logic [FFAL_REQ_DATA_W-1:0] word);
      logic [FFAL_REQ_W-1:0]   kind;
      logic [FFAL_PAGES_W-1:0] pages;
      logic [FFAL_FRAME_W-1:0] frame;
      grant_type               g;
      kind     = word[1:0];
      pages    = word[9:2];
      frame    = word[21:10];
      g.status = ST_OK;
      g.frame  = '0;
      case (kind)
         REQ_INIT: begin
            build_free_list();
         end
         REQ_ALLOC: begin
            if (!list_ready)
               g.status = ST_NOT_INIT;
            else if (pages != 8'd1)
               g.status = ST_SIZE;
            else if (head >= NIL_FRAME)
               g.status = ST_EMPTY;
            else begin
               g.frame = head[FFAL_FRAME_W-1:0];
               head    = link_mem[head[FFAL_FRAME_W-1:0]];
            end
         end
         REQ_FREE: begin
            if (!list_ready)
               g.status = ST_NOT_INIT;
            else if ({1'b0, frame} >= live_count)
               g.status = ST_BAD_FRAME;
            else begin
               link_mem[frame] = head;
               head            = {1'b0, frame};
            end
         end
         default: ;
      endcase
      due_grants.push_back(g);
   endtask

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         cfg_count  = FFAL_COUNT_RST;
         cfg_first  = FFAL_FIRST_RST;
         head       = NIL_FRAME;
         list_ready = 1'b0;
         live_count = '0;
         due_grants.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_grants.size() == 0) begin
               flag_error("response word with no request outstanding", rsp_tdata, 0);
            end else begin
               want = due_grants.pop_front();
               if (rsp_tdata[2:0] != want.status)
                  flag_error("status", rsp_tdata[2:0], want.status);
               if (rsp_tdata[14:3] != want.frame)
                  flag_error("frame_index", rsp_tdata[14:3], want.frame);
            end
         end
         if (req_tvalid && req_tready)
            apply_request(req_tdata);
         if (csr_we) begin
            case (ffal_csr_type'(csr_index))
               CSR_FRAME_COUNT: cfg_count = csr_wdata;
               CSR_FIRST_FREE:  cfg_first = csr_wdata[FFAL_FRAME_W-1:0];
               default: ;
            endcase
         end
      end
      pending = due_grants.size();
   end

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the free frame list allocator.
// ----------------------------------------------------------------------------
// A directed part covers requests before init, pops to empty, bad page
// counts, bad and double frees, empty and saturated tables and the unused
// request code. Random phases then reprogram the table while idle, mostly
// init, and run mixed alloc and free traffic with random gaps on both sides.
// ffal_checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
   import ffal_pkg::*;

   localparam logic [FFAL_REQ_W-1:0] REQ_SPARE = 2'd3;
   localparam int ITEM_GOAL = 1700;

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       csr_we     = 1'b0;
   logic [FFAL_CSR_IDX_W-1:0]  csr_index  = CSR_FRAME_COUNT;
   logic [FFAL_COUNT_W-1:0]    csr_wdata  = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // [1:0] req_type, [9:2] page_count, [21:10] free_frame, [23:22] zero
   logic [FFAL_REQ_DATA_W-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // [2:0] status, [14:3] frame_index, [15] zero
   logic [FFAL_RSP_DATA_W-1:0] rsp_tdata;
   logic                       rsp_took   = 1'b0;

   int pending;
   int errors;
   int words_sent = 0;
   bit req_burst  = 1'b0;

   free_frame_list_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ffal_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .pending    (pending),
      .errors     (errors)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // response side: random stall after each word, with stretches of none
   always @(posedge clock)
      rsp_took <= rsp_tvalid && rsp_tready;

   initial begin
      int stall;
      int taken;
      bit quiet;
      stall = 0;
      taken = 0;
      quiet = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_took) begin
            taken++;
            if (taken % 64 == 0)
               quiet = ($urandom_range(0, 2) == 0);
            stall = quiet ? 0 : $urandom_range(0, 12);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [FFAL_REQ_W-1:0] kind,
                            input logic [FFAL_PAGES_W-1:0] pages,
                            input logic [FFAL_FRAME_W-1:0] frame);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, frame, pages, kind};
      do @(posedge clock); while (!req_tready);
      if (kind != REQ_SPARE)
         words_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_table(input logic [FFAL_COUNT_W-1:0] count,
                            input logic [FFAL_FRAME_W-1:0] first);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_COUNT;
      csr_wdata <= count;
      @(negedge clock);
      csr_index <= CSR_FIRST_FREE;
      csr_wdata <= {1'b0, first};
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int  fc;
      int  first;
      int  lim;
      int  len;
      int  r;
      int  s;
      int  pg;
      int  fr;
      bit  big;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // before any init
      send_word(REQ_ALLOC, 8'd1, 12'd0);
      send_word(REQ_FREE, 8'd0, 12'd5);
      send_word(REQ_ALLOC, 8'd0, 12'd0);
      send_word(REQ_SPARE, 8'd255, 12'd4095);

      // small table: pop to empty, size errors, bad and double frees
      set_table(13'd4, 12'd1);
      send_word(REQ_INIT, 8'd0, 12'd0);
      repeat (4) send_word(REQ_ALLOC, 8'd1, 12'd0);
      send_word(REQ_ALLOC, 8'd0, 12'd0);
      send_word(REQ_ALLOC, 8'd255, 12'd4095);
      send_word(REQ_FREE, 8'd1, 12'd4);
      send_word(REQ_FREE, 8'd1, 12'd4095);
      send_word(REQ_FREE, 8'd0, 12'd0);
      send_word(REQ_FREE, 8'd0, 12'd0);
      send_word(REQ_ALLOC, 8'd1, 12'd0);
      send_word(REQ_SPARE, 8'd0, 12'd0);

      // zero frames
      set_table(13'd0, 12'd0);
      send_word(REQ_INIT, 8'd0, 12'd0);
      send_word(REQ_ALLOC, 8'd1, 12'd0);
      send_word(REQ_FREE, 8'd0, 12'd0);

      // first free past the count
      set_table(13'd10, 12'd4095);
      send_word(REQ_INIT, 8'd0, 12'd0);
      send_word(REQ_ALLOC, 8'd1, 12'd0);
      send_word(REQ_FREE, 8'd0, 12'd9);
      send_word(REQ_ALLOC, 8'd1, 12'd0);

      // saturated count, full table
      set_table(13'd8191, 12'd0);
      send_word(REQ_INIT, 8'd0, 12'd0);
      send_word(REQ_ALLOC, 8'd1, 12'd0);
      send_word(REQ_FREE, 8'd0, 12'd4095);
      send_word(REQ_ALLOC, 8'd1, 12'd0);

      while (words_sent < ITEM_GOAL + 30) begin
         big = ($urandom_range(0, 7) == 0);
         if (big) begin
            fc    = $urandom_range(0, 8191);
            first = $urandom_range(0, 4095);
         end else begin
            fc    = $urandom_range(0, 48);
            first = $urandom_range(0, fc + 3);
         end
         lim = (fc > FFAL_MAX_FRAMES) ? FFAL_MAX_FRAMES : fc;
         set_table(FFAL_COUNT_W'(fc), FFAL_FRAME_W'(first));
         req_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) != 0)
            send_word(REQ_INIT, FFAL_PAGES_W'($urandom_range(0, 255)),
                      FFAL_FRAME_W'($urandom_range(0, 4095)));
         len = $urandom_range(30, 120);
         repeat (len) begin
            r  = $urandom_range(0, 99);
            pg = $urandom_range(0, 255);
            fr = $urandom_range(0, 4095);
            if (r < 50) begin
               send_word(REQ_ALLOC, 8'd1, FFAL_FRAME_W'(fr));
            end else if (r < 55) begin
               if (pg == 1)
                  pg = 0;
               send_word(REQ_ALLOC, FFAL_PAGES_W'(pg), FFAL_FRAME_W'(fr));
            end else if (r < 93) begin
               s = $urandom_range(0, 9);
               if (s < 7 && lim > 0)
                  fr = $urandom_range(0, lim - 1);
               else if (s < 9)
                  fr = (lim + $urandom_range(0, 2) - 1) & 12'hFFF;
               send_word(REQ_FREE, FFAL_PAGES_W'(pg), FFAL_FRAME_W'(fr));
            end else if (r < 96) begin
               send_word(REQ_SPARE, FFAL_PAGES_W'(pg), FFAL_FRAME_W'(fr));
            end else if (!big) begin
               send_word(REQ_INIT, FFAL_PAGES_W'(pg), FFAL_FRAME_W'(fr));
            end else begin
               send_word(REQ_ALLOC, 8'd1, FFAL_FRAME_W'(fr));
            end
         end
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
